>>> sv/dvrt_pkg.sv
// Package of shared types, codes and sizes for the distance-vector route table.
`timescale 1ns / 1ps
`default_nettype none

package dvrt_pkg;

    // Table geometry
    localparam int ADDR_BITS     = 8;
    localparam int MAX_NEXT_HOPS = 3;
    localparam int TABLE_DEPTH   = 1 << ADDR_BITS;
    localparam int CNT_W         = $clog2(MAX_NEXT_HOPS + 1);
    localparam int SHOWN_HOPS    = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_BITS-1:0] t_addr;

    // Request kinds
    typedef enum logic {
        KIND_ADVERT = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    // Result codes
    typedef enum logic [2:0] {
        ST_ADDED       = 3'd0,
        ST_REPLACED    = 3'd1,
        ST_EQUAL       = 3'd2,
        ST_WORSE       = 3'd3,
        ST_FULL        = 3'd4,
        ST_LOOKUP_HIT  = 3'd5,
        ST_LOOKUP_MISS = 3'd6
    } t_status;

    // Back-end sequencer states
    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } t_bk_state;

    // Classified request handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic       is_own;
        t_addr      dst;
        logic [7:0] cost;
        t_addr      src;
    } t_qent;

    // Stored route record: best cost, hop count, hops in ascending order
    typedef struct packed {
        logic [7:0]                   cost;
        logic [CNT_W-1:0]             count;
        t_addr [MAX_NEXT_HOPS-1:0]    hops;
    } t_rec;

    // Result as presented on the output channel
    typedef struct packed {
        t_status                     status;
        logic [7:0]                  cost;
        logic [1:0]                  count;
        logic [SHOWN_HOPS-1:0][7:0]  hops;
    } t_result;

endpackage

`default_nettype wire

>>> sv/dvrt_ifs.sv
// Channel interfaces of the route table: request, result and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface dvrt_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] destination;
    logic [7:0] metric;
    logic [7:0] src_addr;

    modport source (output valid, kind, destination, metric, src_addr, input ready);
    modport sink   (input valid, kind, destination, metric, src_addr, output ready);
endinterface

interface dvrt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] best_cost;
    logic [1:0] hop_count;
    logic [7:0] next_hop_first;
    logic [7:0] next_hop_second;
    logic [7:0] next_hop_third;

    modport source (output valid, status, best_cost, hop_count, next_hop_first,
                    next_hop_second, next_hop_third, input ready);
    modport sink   (input valid, status, best_cost, hop_count, next_hop_first,
                    next_hop_second, next_hop_third, output ready);
endinterface

interface dvrt_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> sv/dvrt_front.sv
// Front end: holds the own address, accepts requests and classifies them for the queue.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_front
    import dvrt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dvrt_in_if.sink     i_in,
    dvrt_cfg_if.sink    i_cfg,
    input  wire logic   i_q_full,
    output logic        o_push,
    output t_qent       o_qent
);

    logic [7:0] r_own;
    t_addr      dst;

    // Own address register, writable at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= '0;
        end else if (i_cfg.valid) begin
            r_own <= i_cfg.data;
        end
    end

    // Accept while the queue has room
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // Mask addresses, saturate the cost, flag the own address
    assign dst = t_addr'(i_in.destination);

    always_comb begin
        o_qent.kind   = t_kind'(i_in.kind);
        o_qent.dst    = dst;
        o_qent.src    = t_addr'(i_in.src_addr);
        o_qent.is_own = (dst == t_addr'(r_own));
        o_qent.cost   = (i_in.metric == 8'hFF) ? 8'hFF : i_in.metric + 8'd1;
    end

endmodule

`default_nettype wire

>>> sv/dvrt_queue.sv
// Short FIFO that decouples the front end from the table back end.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_queue
    import dvrt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_qent  i_data,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_valid,
    output t_qent       o_data
);

    t_qent              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Store pushed requests
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/dvrt_back.sv
// Back end: table memory, per-entry valid bits and the read-modify-write sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dvrt_back
    import dvrt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_valid,
    input  wire t_qent  i_q_data,
    output logic        o_pop,
    dvrt_out_if.source  o_out
);

    t_rec                   r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    t_rec                   r_rdata;
    t_qent                  r_item;
    t_bk_state              r_state;
    t_bk_state              n_state;
    logic                   r_out_valid;
    t_result                r_out;
    t_result                n_out;
    t_rec                   n_rec;
    logic                   out_free;
    logic                   done;
    logic                   mem_we;
    logic                   ent_valid;
    logic                   held;
    logic [CNT_W-1:0]       pos;
    t_addr [MAX_NEXT_HOPS-1:0] shifted;
    t_rec                   shown_rec;
    logic                   shown_zero;
    t_status                status;

    assign out_free  = !r_out_valid || o_out.ready;
    assign ent_valid = r_valid[r_item.dst];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_q_valid) n_state = BK_EXEC;
            BK_EXEC: if (out_free)  n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_pop = 1'b0;
        done  = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = i_q_valid;
            BK_EXEC: done  = out_free;
            default: begin
                o_pop = 1'b0;
                done  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch the popped request and read its table entry
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item  <= i_q_data;
            r_rdata <= r_mem[i_q_data.dst];
        end
    end

    // Update the record: replace, join the equal-cost set or keep it
    always_comb begin
        n_rec = r_rdata;
        held  = 1'b0;
        pos   = '0;
        shifted[0] = r_item.src;
        for (int j = 1; j < MAX_NEXT_HOPS; j++) begin
            shifted[j] = r_rdata.hops[j-1];
        end
        for (int i = 0; i < MAX_NEXT_HOPS; i++) begin
            if (CNT_W'(i) < r_rdata.count) begin
                if (r_rdata.hops[i] == r_item.src) held = 1'b1;
                if (r_rdata.hops[i] < r_item.src)  pos = pos + 1'b1;
            end
        end

        if (r_item.is_own) begin
            status = (r_item.kind == KIND_LOOKUP) ? ST_LOOKUP_HIT : ST_WORSE;
        end else if (r_item.kind == KIND_LOOKUP) begin
            status = ent_valid ? ST_LOOKUP_HIT : ST_LOOKUP_MISS;
        end else if (!ent_valid || r_item.cost < r_rdata.cost) begin
            status        = ent_valid ? ST_REPLACED : ST_ADDED;
            n_rec.cost    = r_item.cost;
            n_rec.count   = CNT_W'(1);
            n_rec.hops[0] = r_item.src;
        end else if (r_item.cost > r_rdata.cost) begin
            status = ST_WORSE;
        end else if (held) begin
            status = ST_EQUAL;
        end else if (r_rdata.count < CNT_W'(MAX_NEXT_HOPS)) begin
            // Insert keeping ascending order
            status      = ST_EQUAL;
            n_rec.count = r_rdata.count + 1'b1;
            for (int j = 0; j < MAX_NEXT_HOPS; j++) begin
                if (CNT_W'(j) < pos) begin
                    n_rec.hops[j] = r_rdata.hops[j];
                end else if (CNT_W'(j) == pos) begin
                    n_rec.hops[j] = r_item.src;
                end else begin
                    n_rec.hops[j] = shifted[j];
                end
            end
        end else begin
            status = ST_FULL;
        end
    end

    // Build the result: own address gives cost zero with hop zero
    always_comb begin
        shown_rec  = n_rec;
        shown_zero = 1'b0;
        if (r_item.is_own) begin
            shown_rec.cost  = '0;
            shown_rec.count = CNT_W'(1);
            shown_rec.hops  = '0;
        end else if (r_item.kind == KIND_LOOKUP && !ent_valid) begin
            shown_zero = 1'b1;
        end
        n_out.status = status;
        n_out.cost   = shown_zero ? 8'd0 : shown_rec.cost;
        n_out.count  = shown_zero ? 2'd0 :
                       (int'(shown_rec.count) > SHOWN_HOPS) ? 2'd3 : 2'(shown_rec.count);
        for (int k = 0; k < SHOWN_HOPS; k++) begin
            n_out.hops[k] = 8'd0;
            if (k < MAX_NEXT_HOPS && !shown_zero) begin
                if (CNT_W'(k) < shown_rec.count) begin
                    n_out.hops[k] = 8'(shown_rec.hops[k]);
                end
            end
        end
    end

    // Write back advertisements for foreign destinations
    assign mem_we = done && (r_item.kind == KIND_ADVERT) && !r_item.is_own;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_item.dst] <= n_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (mem_we) begin
            r_valid[r_item.dst] <= 1'b1;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_out.status;
    assign o_out.best_cost       = r_out.cost;
    assign o_out.hop_count       = r_out.count;
    assign o_out.next_hop_first  = r_out.hops[0];
    assign o_out.next_hop_second = r_out.hops[1];
    assign o_out.next_hop_third  = r_out.hops[2];

endmodule

`default_nettype wire

>>> sv/distance_vector_route_table.sv
// Top level of the distance-vector route table with equal-cost next hops.
//
// Requests (advertisements and lookups) enter a front end that masks addresses,
// saturates the cost at metric plus one and flags the own address, then wait in
// a two-entry queue. The back end works one request at a time: on a pop it
// registers the destination's record from the table memory; once the output
// register is free it updates the record, writes it back and loads the output
// register, and only then takes the next request. The front keeps accepting
// while a result waits to be taken, until the queue fills. Valid bits per
// destination sit in flip-flops cleared by reset, so no clearing pass runs.
// The own address may be rewritten only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_route_table
    import dvrt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dvrt_in_if.sink     i_in,
    dvrt_cfg_if.sink    i_cfg,
    dvrt_out_if.source  o_out
);

    logic   push;
    logic   q_full;
    logic   q_valid;
    logic   pop;
    t_qent  push_data;
    t_qent  q_data;

    dvrt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_qent   (push_data)
    );

    dvrt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    dvrt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
